[hw/rtl/assert_macros.svh]
// Assertion macros for the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and synchronous reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion on the default clock and reset names.
`define ASSERT_STD(label, prop, msg) \
   `ASSERT_CLK(label, clock, reset, prop, msg)

`endif

[hw/rtl/rcct_pkg.sv]
// Shared types, widths and codes of the routing congestion cost table.
package rcct_pkg;

   localparam int NODE_COUNT_DEF = 4096;
   localparam int OCC_BITS_DEF   = 10;

   localparam int NODE_W      = 12;
   localparam int CAP_W       = 10;
   localparam int DELTA_W     = 11;
   localparam int FACTOR_W    = 16;
   localparam int COST_W      = 32;
   localparam int OUT_OCC_W   = 10;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 1;

   localparam logic [COST_W-1:0]   COST_ONE      = 32'h0001_0000;
   localparam logic [COST_W-1:0]   COST_MAX      = 32'hFFFF_FFFF;
   localparam logic [FACTOR_W-1:0] FACTOR_RESET  = 16'd256;

   localparam logic KIND_OCCUPANCY = 1'b0;
   localparam logic KIND_HISTORY   = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_PRESENT_FACTOR = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HISTORY_FACTOR = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK,
      STATUS_CLAMP_LOW,
      STATUS_CLAMP_HIGH
   } status_type;

   typedef struct packed {
      logic                      kind;
      logic [CAP_W-1:0]          capacity;
      logic signed [DELTA_W-1:0] delta;
      logic                      path_end;
      logic                      in_range;
   } item_type;

   typedef struct packed {
      logic prep_en;
      logic mul_en;
   } calc_ctrl_type;

endpackage

[hw/rtl/routing_congestion_cost_table_unit.sv]
// Top level of the routing congestion cost table.
//
// Keeps an occupancy, a present cost and a history cost (both unsigned Q16.16) for each
// routing node in one table memory, and answers every request item with one response item
// that shows the node after the update. An occupancy item (kind 0) adds a signed delta,
// clamps it to 0 .. 2^OCC_BITS-1 and recomputes the present cost; a history item (kind 1)
// grows the history cost of an over-used node and refreshes its present cost. A node index
// of NODE_COUNT or more leaves the table alone and returns occupancy 0 with both costs 1.0.
// After reset the block sweeps the table to its cleared values, one entry a cycle, and takes
// no item until the sweep is done; CSR writes are taken during the sweep. Each item then
// goes through to its write-back before the next accept: the table read, an occupancy
// clamp stage, a multiply stage and a saturate and write-back stage run one after another
// on the single table port pair, so one item is in flight at a time. A finished response
// waits in the output register while the next item is accepted. CSR writes belong to idle
// periods only.
module routing_congestion_cost_table_unit #(
   parameter int NODE_COUNT = rcct_pkg::NODE_COUNT_DEF,
   parameter int OCC_BITS   = rcct_pkg::OCC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,

   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_kind,
   input  logic [rcct_pkg::NODE_W-1:0]            req_node_index,
   input  logic [rcct_pkg::CAP_W-1:0]             req_capacity,
   input  logic signed [rcct_pkg::DELTA_W-1:0]    req_occupancy_delta,
   input  logic                                   req_path_end,

   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [rcct_pkg::OUT_OCC_W-1:0]         rsp_new_occupancy,
   output logic [rcct_pkg::COST_W-1:0]            rsp_present_cost,
   output logic [rcct_pkg::COST_W-1:0]            rsp_history_cost,
   output logic [rcct_pkg::STATUS_W-1:0]          rsp_status,
   output logic                                   rsp_path_done,

   input  logic                                   csr_write_enable,
   input  logic [rcct_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [rcct_pkg::FACTOR_W-1:0]          csr_write_data
);

   import rcct_pkg::*;

   localparam int ADDR_W = $clog2(NODE_COUNT);
   localparam int MEM_W  = OCC_BITS + 2 * COST_W;
   localparam logic [MEM_W-1:0]  CLEAR_WORD = {{OCC_BITS{1'b0}}, COST_ONE, COST_ONE};
   localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(NODE_COUNT - 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_PREP,
      S_MUL,
      S_FIN
   } state_type;

   state_type            state_ff, state_in;
   item_type             item_ff, item_in;
   logic [ADDR_W-1:0]    addr_ff, addr_in;
   logic [ADDR_W-1:0]    clear_addr_ff, clear_addr_in;
   logic [FACTOR_W-1:0]  pf_ff, pf_in;
   logic [FACTOR_W-1:0]  hf_ff, hf_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OUT_OCC_W-1:0] rsp_occ_ff, rsp_occ_in;
   logic [COST_W-1:0]    rsp_present_ff, rsp_present_in;
   logic [COST_W-1:0]    rsp_history_ff, rsp_history_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic                 rsp_done_ff, rsp_done_in;

   logic                 mem_wr_en;
   logic [ADDR_W-1:0]    mem_wr_addr;
   logic [MEM_W-1:0]     mem_wr_data;
   logic                 mem_rd_en;
   logic [MEM_W-1:0]     mem_rd_data;

   calc_ctrl_type        calc_ctrl;
   logic [OCC_BITS-1:0]  new_occ;
   logic [COST_W-1:0]    new_present;
   logic [COST_W-1:0]    new_history;
   status_type           new_status;

   assign req_ready = (state_ff == S_IDLE);
   // read the node entry at the accept edge; one item in flight, so no
   // write-back can race this read
   assign mem_rd_en = req_valid && req_ready;

   rcct_store #(
      .DEPTH  (NODE_COUNT),
      .ADDR_W (ADDR_W),
      .DATA_W (MEM_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (ADDR_W'(req_node_index)),
      .rd_data (mem_rd_data)
   );

   assign calc_ctrl.prep_en = (state_ff == S_PREP);
   assign calc_ctrl.mul_en  = (state_ff == S_MUL);

   rcct_calc #(
      .OCC_BITS (OCC_BITS)
   ) u_calc (
      .clock          (clock),
      .ctrl           (calc_ctrl),
      .item           (item_ff),
      .old_occ        (mem_rd_data[MEM_W-1 -: OCC_BITS]),
      .old_present    (mem_rd_data[2*COST_W-1 -: COST_W]),
      .old_history    (mem_rd_data[COST_W-1:0]),
      .present_factor (pf_ff),
      .history_factor (hf_ff),
      .new_occ        (new_occ),
      .new_present    (new_present),
      .new_history    (new_history),
      .new_status     (new_status)
   );

   always_comb begin
      state_in       = state_ff;
      item_in        = item_ff;
      addr_in        = addr_ff;
      clear_addr_in  = clear_addr_ff;
      pf_in          = pf_ff;
      hf_in          = hf_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_occ_in     = rsp_occ_ff;
      rsp_present_in = rsp_present_ff;
      rsp_history_in = rsp_history_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_done_in    = rsp_done_ff;
      mem_wr_en      = 1'b0;
      mem_wr_addr    = addr_ff;
      mem_wr_data    = {new_occ, new_present, new_history};

      // drop the response once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // factor registers
      if (csr_write_enable) begin
         case (csr_index)
            CSR_PRESENT_FACTOR: pf_in = csr_write_data;
            CSR_HISTORY_FACTOR: hf_in = csr_write_data;
            default:            ;
         endcase
      end

      case (state_ff)
         S_CLEAR: begin
            // sweep the table to occupancy 0, costs 1.0
            mem_wr_en     = 1'b1;
            mem_wr_addr   = clear_addr_ff;
            mem_wr_data   = CLEAR_WORD;
            clear_addr_in = clear_addr_ff + ADDR_W'(1);
            if (clear_addr_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               item_in.kind     = req_kind;
               item_in.capacity = req_capacity;
               item_in.delta    = req_occupancy_delta;
               item_in.path_end = req_path_end;
               item_in.in_range = (32'(req_node_index) < 32'(NODE_COUNT));
               addr_in          = ADDR_W'(req_node_index);
               state_in         = S_PREP;
            end
         end
         S_PREP: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            state_in = S_FIN;
         end
         S_FIN: begin
            // hold here until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               mem_wr_en    = item_ff.in_range;
               rsp_valid_in = 1'b1;
               rsp_done_in  = item_ff.path_end;
               if (item_ff.in_range) begin
                  rsp_occ_in     = OUT_OCC_W'(new_occ);
                  rsp_present_in = new_present;
                  rsp_history_in = new_history;
                  rsp_status_in  = new_status;
               end else begin
                  rsp_occ_in     = '0;
                  rsp_present_in = COST_ONE;
                  rsp_history_in = COST_ONE;
                  rsp_status_in  = STATUS_OK;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clear_addr_ff <= '0;
         pf_ff         <= FACTOR_RESET;
         hf_ff         <= FACTOR_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clear_addr_ff  <= clear_addr_in;
         pf_ff          <= pf_in;
         hf_ff          <= hf_in;
         rsp_valid_ff   <= rsp_valid_in;
         item_ff        <= item_in;
         addr_ff        <= addr_in;
         rsp_occ_ff     <= rsp_occ_in;
         rsp_present_ff <= rsp_present_in;
         rsp_history_ff <= rsp_history_in;
         rsp_status_ff  <= rsp_status_in;
         rsp_done_ff    <= rsp_done_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_new_occupancy = rsp_occ_ff;
   assign rsp_present_cost  = rsp_present_ff;
   assign rsp_history_cost  = rsp_history_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_path_done     = rsp_done_ff;

endmodule

[hw/rtl/rcct_store.sv]
// Node table memory: one write port, one registered read port.
module rcct_store #(
   parameter int DEPTH  = rcct_pkg::NODE_COUNT_DEF,
   parameter int ADDR_W = 12,
   parameter int DATA_W = 74
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] store_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/rcct_calc.sv]
// Occupancy update and cost arithmetic: prepare, multiply, then add and saturate.
module rcct_calc #(
   parameter int OCC_BITS = rcct_pkg::OCC_BITS_DEF
) (
   input  logic                            clock,
   input  rcct_pkg::calc_ctrl_type         ctrl,
   input  rcct_pkg::item_type              item,
   input  logic [OCC_BITS-1:0]             old_occ,
   input  logic [rcct_pkg::COST_W-1:0]     old_present,
   input  logic [rcct_pkg::COST_W-1:0]     old_history,
   input  logic [rcct_pkg::FACTOR_W-1:0]   present_factor,
   input  logic [rcct_pkg::FACTOR_W-1:0]   history_factor,
   output logic [OCC_BITS-1:0]             new_occ,
   output logic [rcct_pkg::COST_W-1:0]     new_present,
   output logic [rcct_pkg::COST_W-1:0]     new_history,
   output rcct_pkg::status_type            new_status
);

   import rcct_pkg::*;

   typedef enum logic [1:0] {
      PRES_KEEP,
      PRES_ONE,
      PRES_CONGESTED
   } pres_sel_type;

   localparam int SUM_W   = ((OCC_BITS > DELTA_W) ? OCC_BITS : DELTA_W) + 2;
   localparam int CNT_W   = ((OCC_BITS > CAP_W) ? OCC_BITS : CAP_W) + 1;
   localparam int PROD_W  = CNT_W + FACTOR_W;
   localparam int SHIFT_W = PROD_W + 8;
   localparam logic signed [SUM_W-1:0] OCC_LIMIT = SUM_W'((64'd1 << OCC_BITS) - 64'd1);

   logic signed [SUM_W-1:0] sum_c;
   logic [OCC_BITS-1:0]     occ_c;
   status_type              status_c;
   logic [CNT_W-1:0]        occ_w;
   logic [CNT_W-1:0]        cap_w;
   logic [CNT_W-1:0]        cnt_p_c;
   logic [CNT_W-1:0]        cnt_h_c;
   pres_sel_type            pres_sel_c;
   logic                    hist_upd_c;

   logic [OCC_BITS-1:0]     occ_ff;
   status_type              status_ff;
   pres_sel_type            pres_sel_ff;
   logic                    hist_upd_ff;
   logic [CNT_W-1:0]        cnt_p_ff;
   logic [CNT_W-1:0]        cnt_h_ff;
   logic [PROD_W-1:0]       prod_p_ff;
   logic [PROD_W-1:0]       prod_h_ff;

   logic [SHIFT_W-1:0]      shift_p;
   logic [SHIFT_W-1:0]      shift_h;
   logic [COST_W-1:0]       scaled_p;
   logic [COST_W-1:0]       scaled_h;
   logic [COST_W:0]         sum_p;
   logic [COST_W:0]         sum_h;
   logic [COST_W-1:0]       congested;

   // clamp the new occupancy and pick what the costs become
   always_comb begin
      sum_c      = $signed(SUM_W'(old_occ)) + SUM_W'(item.delta);
      occ_c      = old_occ;
      status_c   = STATUS_OK;
      if (item.kind == KIND_OCCUPANCY) begin
         if (sum_c[SUM_W-1]) begin
            occ_c    = '0;
            status_c = STATUS_CLAMP_LOW;
         end else if (sum_c > OCC_LIMIT) begin
            occ_c    = OCC_LIMIT[OCC_BITS-1:0];
            status_c = STATUS_CLAMP_HIGH;
         end else begin
            occ_c    = sum_c[OCC_BITS-1:0];
         end
      end
      occ_w      = CNT_W'(occ_c);
      cap_w      = CNT_W'(item.capacity);
      cnt_p_c    = occ_w + CNT_W'(1) - cap_w;
      cnt_h_c    = occ_w - cap_w;
      pres_sel_c = PRES_KEEP;
      hist_upd_c = 1'b0;
      if (item.kind == KIND_OCCUPANCY) begin
         pres_sel_c = (occ_w < cap_w) ? PRES_ONE : PRES_CONGESTED;
      end else begin
         if (occ_w >= cap_w) begin
            pres_sel_c = PRES_CONGESTED;
         end
         hist_upd_c = (occ_w > cap_w);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.prep_en) begin
         occ_ff      <= occ_c;
         status_ff   <= status_c;
         pres_sel_ff <= pres_sel_c;
         hist_upd_ff <= hist_upd_c;
         cnt_p_ff    <= cnt_p_c;
         cnt_h_ff    <= cnt_h_c;
      end
      if (ctrl.mul_en) begin
         prod_p_ff <= cnt_p_ff * present_factor;
         prod_h_ff <= cnt_h_ff * history_factor;
      end
   end

   // Q8.8 product to Q16.16, then saturating adds
   always_comb begin
      shift_p   = {prod_p_ff, 8'd0};
      shift_h   = {prod_h_ff, 8'd0};
      scaled_p  = (|shift_p[SHIFT_W-1:COST_W]) ? COST_MAX : shift_p[COST_W-1:0];
      scaled_h  = (|shift_h[SHIFT_W-1:COST_W]) ? COST_MAX : shift_h[COST_W-1:0];
      sum_p     = {1'b0, COST_ONE} + {1'b0, scaled_p};
      sum_h     = {1'b0, old_history} + {1'b0, scaled_h};
      congested = sum_p[COST_W] ? COST_MAX : sum_p[COST_W-1:0];
      case (pres_sel_ff)
         PRES_ONE:       new_present = COST_ONE;
         PRES_CONGESTED: new_present = congested;
         default:        new_present = old_present;
      endcase
      if (hist_upd_ff) begin
         new_history = sum_h[COST_W] ? COST_MAX : sum_h[COST_W-1:0];
      end else begin
         new_history = old_history;
      end
   end

   assign new_occ    = occ_ff;
   assign new_status = status_ff;

endmodule

[hw/rtl/rcct_checker.sv]
// Port-level checks of the routing congestion cost table, bound to the top level.
`include "assert_macros.svh"

module rcct_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [rcct_pkg::OUT_OCC_W-1:0]      rsp_new_occupancy,
   input logic [rcct_pkg::COST_W-1:0]         rsp_present_cost,
   input logic [rcct_pkg::COST_W-1:0]         rsp_history_cost,
   input logic [rcct_pkg::STATUS_W-1:0]       rsp_status
);

   import rcct_pkg::*;

   // a stalled response keeps its costs
   `ASSERT_STD(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_present_cost) && $stable(rsp_history_cost), "response changed while stalled")

   // one item in flight: no accept right after an accept
   `ASSERT_STD(a_one_in_flight, req_valid && req_ready |=> !req_ready, "request ready right after an accept")

   // costs never drop below 1.0
   `ASSERT_STD(a_cost_floor, rsp_valid |-> rsp_present_cost >= COST_ONE && rsp_history_cost >= COST_ONE, "cost below 1.0")

   // a clamp at zero reports zero occupancy
   `ASSERT_STD(a_clamp_low, rsp_valid && rsp_status == STATUS_CLAMP_LOW |-> rsp_new_occupancy == '0, "low clamp with nonzero occupancy")

endmodule

bind routing_congestion_cost_table_unit rcct_checker u_checker (.*);

[verif/routing_congestion_cost_table_unit_tb.sv]
// Self-checking testbench of the routing congestion cost table unit.
`timescale 1ns / 1ps

module routing_congestion_cost_table_unit_tb;
   import rcct_pkg::*;

   localparam int OCC_LIMIT  = (1 << OCC_BITS_DEF) - 1;
   localparam int PHASES     = 5;
   localparam int PER_PHASE  = 150;
   localparam int POOL_SIZE  = 16;
   localparam int PRINT_CAP  = 30;

   // One request item as the block sees it.
   typedef struct packed {
      logic                      kind;
      logic [NODE_W-1:0]         node;
      logic [CAP_W-1:0]          cap;
      logic signed [DELTA_W-1:0] delta;
      logic                      path_end;
   } cost_update_type;

   // One response item: the node after the update.
   typedef struct packed {
      logic [OUT_OCC_W-1:0] occ;
      logic [COST_W-1:0]    present;
      logic [COST_W-1:0]    history;
      status_type           status;
      logic                 path_done;
   } node_report_type;

   // A row of the directed table; typed rows carry their own answer.
   typedef struct packed {
      cost_update_type upd;
      logic            has_typed;
      node_report_type typed;
   } directed_row_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic                      req_kind;
   logic [NODE_W-1:0]         req_node_index;
   logic [CAP_W-1:0]          req_capacity;
   logic signed [DELTA_W-1:0] req_occupancy_delta;
   logic                      req_path_end;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [OUT_OCC_W-1:0]      rsp_new_occupancy;
   logic [COST_W-1:0]         rsp_present_cost;
   logic [COST_W-1:0]         rsp_history_cost;
   logic [STATUS_W-1:0]       rsp_status;
   logic                      rsp_path_done;
   logic                      csr_write_enable;
   logic [CSR_INDEX_W-1:0]    csr_index;
   logic [FACTOR_W-1:0]       csr_write_data;

   // Shadow copy of the cost table and of the factor registers.
   int unsigned       node_occ     [NODE_COUNT_DEF];
   logic [COST_W-1:0] node_present [NODE_COUNT_DEF];
   logic [COST_W-1:0] node_history [NODE_COUNT_DEF];
   logic [FACTOR_W-1:0] present_factor_q8;
   logic [FACTOR_W-1:0] history_factor_q8;

   // Responses still owed by the block, oldest first.
   node_report_type  pending_reports[$];
   directed_row_type directed_rows[$];

   // Hot nodes of the current phase and their capacities.
   int unsigned pool_node [POOL_SIZE];
   int unsigned pool_cap  [POOL_SIZE];

   bit idle_on;
   bit stall_on;
   int fail_count;
   int items_sent;
   int history_items;
   int reports_seen;
   int clamp_low_seen;
   int clamp_high_seen;
   int saturated_seen;

   routing_congestion_cost_table_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_node_index      (req_node_index),
      .req_capacity        (req_capacity),
      .req_occupancy_delta (req_occupancy_delta),
      .req_path_end        (req_path_end),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_new_occupancy   (rsp_new_occupancy),
      .rsp_present_cost    (rsp_present_cost),
      .rsp_history_cost    (rsp_history_cost),
      .rsp_status          (rsp_status),
      .rsp_path_done       (rsp_path_done),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop far beyond the slowest legal run (sweep plus 771 items with stalls).
   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // ---------------------------------------------------------------- prediction

   function automatic logic [COST_W-1:0] add_sat(logic [COST_W-1:0] a, logic [COST_W-1:0] b);
      logic [COST_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
   endfunction

   // count times a Q8.8 factor, moved to Q16.16, saturated
   function automatic logic [COST_W-1:0] scale_sat(int unsigned count, logic [FACTOR_W-1:0] f);
      longint unsigned prod;
      prod = (64'(count) * 64'(f)) << 8;
      return (prod > 64'hFFFF_FFFF) ? COST_MAX : prod[COST_W-1:0];
   endfunction

   // 1 + (occ + 1 - cap) * present factor, for occ >= cap
   function automatic logic [COST_W-1:0] congested_cost(int unsigned occ, int unsigned cap);
      return add_sat(COST_ONE, scale_sat(occ + 1 - cap, present_factor_q8));
   endfunction

   // Apply one update to the shadow table and return the node as it must read back.
   function automatic node_report_type apply_cost_update(cost_update_type u);
      node_report_type res;
      int              occ_sum;
      int unsigned     occ;
      res.path_done = u.path_end;
      res.status    = STATUS_OK;
      if (u.node >= NODE_COUNT_DEF) begin
         // out-of-range node: table untouched, cleared values reported
         res.occ     = '0;
         res.present = COST_ONE;
         res.history = COST_ONE;
         return res;
      end
      occ = node_occ[u.node];
      if (u.kind == KIND_OCCUPANCY) begin
         occ_sum = int'(occ) + int'($signed(u.delta));
         if (occ_sum < 0) begin
            occ        = 0;
            res.status = STATUS_CLAMP_LOW;
         end else if (occ_sum > OCC_LIMIT) begin
            occ        = OCC_LIMIT;
            res.status = STATUS_CLAMP_HIGH;
         end else begin
            occ = occ_sum;
         end
         node_occ[u.node]     = occ;
         node_present[u.node] = (occ < u.cap) ? COST_ONE : congested_cost(occ, u.cap);
      end else if (occ > u.cap) begin
         // over-used at the end of the iteration: history grows, present refreshed
         node_history[u.node] = add_sat(node_history[u.node],
                                        scale_sat(occ - u.cap, history_factor_q8));
         node_present[u.node] = congested_cost(occ, u.cap);
      end else if (occ == u.cap) begin
         node_present[u.node] = congested_cost(occ, u.cap);
      end
      res.occ     = OUT_OCC_W'(occ);
      res.present = node_present[u.node];
      res.history = node_history[u.node];
      return res;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      if (fail_count < PRINT_CAP)
         $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      fail_count++;
   endtask

   // Compare each accepted response with the oldest expectation.
   always @(posedge clock) begin
      node_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         reports_seen++;
         if (pending_reports.size() == 0) begin
            report_mismatch("response with nothing pending", rsp_present_cost, 0);
         end else begin
            want = pending_reports.pop_front();
            if (rsp_new_occupancy !== want.occ)
               report_mismatch("new_occupancy", rsp_new_occupancy, want.occ);
            if (rsp_present_cost !== want.present)
               report_mismatch("present_cost", rsp_present_cost, want.present);
            if (rsp_history_cost !== want.history)
               report_mismatch("history_cost", rsp_history_cost, want.history);
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_path_done !== want.path_done)
               report_mismatch("path_done", rsp_path_done, want.path_done);
            if (want.status == STATUS_CLAMP_LOW)  clamp_low_seen++;
            if (want.status == STATUS_CLAMP_HIGH) clamp_high_seen++;
            if (want.present == COST_MAX || want.history == COST_MAX) saturated_seen++;
         end
      end
   end

   // Back-pressure the response side on about 6 percent of cycles unless told to keep quiet.
   always @(posedge clock) begin
      rsp_ready <= !stall_on || ($urandom_range(99) >= 6);
   end

   // ---------------------------------------------------------------- stimulus

   // Drive one item, hold it until accepted, then book its expected response.
   // Called on a rising edge; leaves valid high so back-to-back items need no gap.
   task automatic send_update(cost_update_type u, logic has_typed, node_report_type typed);
      node_report_type predicted;
      if (idle_on) begin
         while ($urandom_range(99) < 6) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid           <= 1'b1;
      req_kind            <= u.kind;
      req_node_index      <= u.node;
      req_capacity        <= u.cap;
      req_occupancy_delta <= u.delta;
      req_path_end        <= u.path_end;
      do @(posedge clock); while (!req_ready);
      predicted = apply_cost_update(u);
      pending_reports = {pending_reports, (has_typed ? typed : predicted)};
      items_sent++;
      if (u.kind == KIND_HISTORY) history_items++;
   endtask

   // Wait until every booked response has come back, bounded so a hang still ends.
   task automatic wait_drained();
      int waited;
      waited = 0;
      while (pending_reports.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
   endtask

   // Write both factor registers back to back; only called while the block is idle.
   task automatic write_factors(logic [FACTOR_W-1:0] pf, logic [FACTOR_W-1:0] hf);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_PRESENT_FACTOR;
      csr_write_data   <= pf;
      @(posedge clock);
      csr_index        <= CSR_HISTORY_FACTOR;
      csr_write_data   <= hf;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      present_factor_q8 = pf;
      history_factor_q8 = hf;
   endtask

   task automatic add_row(logic kind, int unsigned node, int unsigned cap, int delta,
                          logic pend, logic has_typed, int unsigned occ,
                          logic [COST_W-1:0] present, logic [COST_W-1:0] history,
                          status_type status);
      directed_row_type row;
      row.upd.kind        = kind;
      row.upd.node        = NODE_W'(node);
      row.upd.cap         = CAP_W'(cap);
      row.upd.delta       = DELTA_W'(delta);
      row.upd.path_end    = pend;
      row.has_typed       = has_typed;
      row.typed.occ       = OUT_OCC_W'(occ);
      row.typed.present   = present;
      row.typed.history   = history;
      row.typed.status    = status;
      row.typed.path_done = pend;
      directed_rows = {directed_rows, row};
   endtask

   // Pick the hot nodes of a phase; the corner nodes are always among them.
   task automatic fill_pool();
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool_node[i] = $urandom_range(NODE_COUNT_DEF - 1);
         pool_cap[i]  = $urandom_range(12);
      end
      pool_node[0] = 0;
      pool_node[1] = NODE_COUNT_DEF - 1;
      pool_cap[2]  = (1 << CAP_W) - 1;
      pool_cap[3]  = 0;
   endtask

   // Mostly realistic router traffic on the hot nodes, some noise over the full ranges.
   function automatic cost_update_type make_random_update();
      cost_update_type u;
      int              slot;
      u.path_end = 1'($urandom_range(1));
      if ($urandom_range(99) < 8) begin
         u.kind  = 1'($urandom_range(1));
         u.node  = NODE_W'($urandom());
         u.cap   = CAP_W'($urandom());
         u.delta = DELTA_W'($urandom());
         return u;
      end
      slot   = $urandom_range(POOL_SIZE - 1);
      u.kind = ($urandom_range(3) == 0) ? KIND_HISTORY : KIND_OCCUPANCY;
      u.node = NODE_W'(pool_node[slot]);
      u.cap  = ($urandom_range(99) < 5) ? CAP_W'($urandom_range(15)) : CAP_W'(pool_cap[slot]);
      // small rip-up and reroute steps with an upward drift, now and then a big jump
      if ($urandom_range(99) < 5)
         u.delta = DELTA_W'($urandom());
      else
         u.delta = DELTA_W'(int'($urandom_range(6)) - 2);
      return u;
   endfunction

   // ---------------------------------------------------------------- main sequence

   initial begin
      node_report_type no_typed;
      logic [FACTOR_W-1:0] pf;
      logic [FACTOR_W-1:0] hf;

      no_typed            = '0;
      fail_count          = 0;
      items_sent          = 0;
      history_items       = 0;
      reports_seen        = 0;
      clamp_low_seen      = 0;
      clamp_high_seen     = 0;
      saturated_seen      = 0;
      idle_on             = 1'b1;
      stall_on            = 1'b1;
      reset               <= 1'b1;
      req_valid           <= 1'b0;
      req_kind            <= KIND_OCCUPANCY;
      req_node_index      <= '0;
      req_capacity        <= '0;
      req_occupancy_delta <= '0;
      req_path_end        <= 1'b0;
      rsp_ready           <= 1'b0;
      csr_write_enable    <= 1'b0;
      csr_index           <= CSR_PRESENT_FACTOR;
      csr_write_data      <= '0;

      // Shadow table starts cleared, factors at their reset value of 1.0.
      for (int n = 0; n < NODE_COUNT_DEF; n++) begin
         node_occ[n]     = 0;
         node_present[n] = COST_ONE;
         node_history[n] = COST_ONE;
      end
      present_factor_q8 = FACTOR_RESET;
      history_factor_q8 = FACTOR_RESET;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed rows, run with the reset factors (1.0 each, so one step is 65536).
      // Typed rows: cleared nodes, clamps, and the at-capacity and below-capacity history cases.
      add_row(KIND_OCCUPANCY, 0, 0, 0, 0, 1, 0, 32'd131072, COST_ONE, STATUS_OK);
      add_row(KIND_OCCUPANCY, 1, 10, -1, 1, 1, 0, COST_ONE, COST_ONE, STATUS_CLAMP_LOW);
      add_row(KIND_OCCUPANCY, 1, 10, -1024, 0, 1, 0, COST_ONE, COST_ONE, STATUS_CLAMP_LOW);
      add_row(KIND_OCCUPANCY, 4095, 1023, 1023, 1, 1, 1023, 32'd131072, COST_ONE, STATUS_OK);
      add_row(KIND_OCCUPANCY, 4095, 1023, 1, 0, 1, 1023, 32'd131072, COST_ONE,
              STATUS_CLAMP_HIGH);
      add_row(KIND_HISTORY, 4095, 1023, 0, 1, 1, 1023, 32'd131072, COST_ONE, STATUS_OK);
      add_row(KIND_HISTORY, 2, 5, 0, 0, 1, 0, COST_ONE, COST_ONE, STATUS_OK);
      // Rows left to the predictor: over-use with history growth, repeated history updates.
      add_row(KIND_HISTORY, 4095, 0, 0, 0, 0, 0, '0, '0, STATUS_OK);
      add_row(KIND_HISTORY, 4095, 0, -1024, 1, 0, 0, '0, '0, STATUS_OK);
      add_row(KIND_OCCUPANCY, 2, 5, 5, 1, 0, 0, '0, '0, STATUS_OK);
      add_row(KIND_OCCUPANCY, 2, 5, 1023, 0, 0, 0, '0, '0, STATUS_OK);
      add_row(KIND_OCCUPANCY, 2, 5, -1023, 1, 0, 0, '0, '0, STATUS_OK);
      add_row(KIND_OCCUPANCY, 3, 1, 3, 0, 0, 0, '0, '0, STATUS_OK);
      add_row(KIND_HISTORY, 3, 1, 0, 1, 0, 0, '0, '0, STATUS_OK);
      add_row(KIND_HISTORY, 3, 1, 0, 0, 0, 0, '0, '0, STATUS_OK);
      add_row(KIND_OCCUPANCY, 3, 4, 0, 0, 0, 0, '0, '0, STATUS_OK);
      add_row(KIND_HISTORY, 3, 3, 0, 1, 0, 0, '0, '0, STATUS_OK);
      // Alternating bit patterns on every field.
      add_row(KIND_OCCUPANCY, 12'hAAA, 10'h2AA, 682, 1, 0, 0, '0, '0, STATUS_OK);
      add_row(KIND_OCCUPANCY, 12'h555, 10'h155, -682, 0, 0, 0, '0, '0, STATUS_OK);
      add_row(KIND_HISTORY, 12'h555, 10'h155, 0, 1, 0, 0, '0, '0, STATUS_OK);
      add_row(KIND_HISTORY, 12'hAAA, 10'h000, 0, 0, 0, 0, '0, '0, STATUS_OK);

      foreach (directed_rows[i])
         send_update(directed_rows[i].upd, directed_rows[i].has_typed, directed_rows[i].typed);

      // Random phases, each under its own factor setting; the table carries over.
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            case (phase)
               1: begin pf = '1; hf = '1; end                // saturate quickly
               2: begin pf = '0; hf = '0; end                // costs stay flat
               3: begin pf = FACTOR_W'($urandom()); hf = FACTOR_W'($urandom()); end
               default: begin pf = 16'd1; hf = FACTOR_W'($urandom()); end
            endcase
            write_factors(pf, hf);
         end
         // phase 3 runs without any idling on either side
         idle_on  = (phase != 3);
         stall_on = (phase != 3);
         fill_pool();
         for (int k = 0; k < PER_PHASE; k++)
            send_update(make_random_update(), 1'b0, no_typed);
         req_valid <= 1'b0;
         wait_drained();
      end

      // Let the last write-back settle, then close out.
      idle_on  = 1'b0;
      stall_on = 1'b0;
      repeat (8) @(posedge clock);
      if (pending_reports.size() != 0)
         report_mismatch("responses never returned", pending_reports.size(), 0);

      $display("covered %0d items (%0d history updates) over %0d factor settings, %0d responses",
               items_sent, history_items, PHASES, reports_seen);
      $display("seen %0d low clamps, %0d high clamps, %0d saturated costs, %0d mismatches",
               clamp_low_seen, clamp_high_seen, saturated_seen, fail_count);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
